@@ hdl/fbe_pkg.sv @@
// Shared types, constants and elaboration-time helpers of the Feistel block cipher.
package fbe_pkg;

  localparam int HALF_W          = 64;
  localparam int KEY_W           = 2 * HALF_W;
  localparam int BYTE_W          = 8;
  localparam int BYTES_PER_HALF  = HALF_W / BYTE_W;
  localparam int SBOX_DEPTH      = 256;
  localparam int ROUND_COUNT_DEF = 32;
  localparam int CFG_IDX_W       = 2;

  // Recurrence of the S-box and the key schedule.
  localparam int                 SBOX_MUL = 37;
  localparam int                 SBOX_ADD = 9;
  localparam int                 ROT_STEP = 7;
  localparam logic [KEY_W-1:0]   KEY_XOR  = KEY_W'(24'hab_cdef);

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [6:0]        rot_t;
  typedef byte_t             sbox_tbl_t [SBOX_DEPTH];

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH  = 2'd0,
    REG_KEY_LOW   = 2'd1,
    REG_SBOX_SEED = 2'd2
  } cfg_reg_t;

  // One pipeline stage: valid flag and the two Feistel halves.
  typedef struct packed {
    logic  valid;
    half_t left;
    half_t right;
  } fbe_stage_t;

  // Left rotation of a 128-bit word.
  function automatic key_t rotl128(key_t x, rot_t amt);
    logic [2*KEY_W-1:0] dbl;
    dbl = {x, x} << amt;
    return dbl[2*KEY_W-1:KEY_W];
  endfunction

  // Entry n of the S-box is MUL_TBL[n] * seed + ADD_TBL[n] (mod 256), since the
  // recurrence is affine in the seed.
  function automatic sbox_tbl_t gen_sbox_mul();
    sbox_tbl_t tbl;
    tbl[0] = 8'd1;
    for (int n = 1; n < SBOX_DEPTH; n++) begin
      tbl[n] = 8'(SBOX_MUL * int'(tbl[n-1]));
    end
    return tbl;
  endfunction

  function automatic sbox_tbl_t gen_sbox_add();
    sbox_tbl_t tbl;
    tbl[0] = 8'd0;
    for (int n = 1; n < SBOX_DEPTH; n++) begin
      tbl[n] = 8'(SBOX_MUL * int'(tbl[n-1]) + SBOX_ADD);
    end
    return tbl;
  endfunction

  localparam sbox_tbl_t SBOX_MUL_TBL = gen_sbox_mul();
  localparam sbox_tbl_t SBOX_ADD_TBL = gen_sbox_add();

  // Round key i is the master key rotated by a fixed total amount, XORed with
  // a fixed word, because rotation and XOR with a constant are both linear.
  function automatic rot_t key_rot_amt(int idx);
    int total;
    total = 0;
    for (int j = 0; j <= idx; j++) begin
      total = (total + ((ROT_STEP * j) & 127)) & 127;
    end
    return rot_t'(total);
  endfunction

  function automatic key_t key_const(int idx);
    key_t k;
    k = '0;
    for (int j = 0; j <= idx; j++) begin
      k = rotl128(k, rot_t'((ROT_STEP * j) & 127)) ^ KEY_XOR;
    end
    return k;
  endfunction

endpackage

@@ hdl/fbe_if.sv @@
// Channel interfaces of the Feistel block cipher: plaintext, ciphertext and configuration.
interface fbe_in_if;
  logic                valid;
  logic                ready;
  fbe_pkg::half_t      block_high;
  fbe_pkg::half_t      block_low;

  modport source (output valid, output block_high, output block_low, input ready);
  modport sink   (input valid, input block_high, input block_low, output ready);
endinterface

interface fbe_out_if;
  logic                valid;
  logic                ready;
  fbe_pkg::half_t      cipher_high;
  fbe_pkg::half_t      cipher_low;

  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface fbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbe_pkg::CFG_IDX_W-1:0]   index;
  logic [fbe_pkg::HALF_W-1:0]      wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/fbe_round.sv @@
// One Feistel round as a registered pipeline stage.
module fbe_round #(
  parameter int ROUND_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  fbe_pkg::key_t       cipher_key,
  input  fbe_pkg::byte_t      sbox_seed,
  input  fbe_pkg::fbe_stage_t stage_in,
  output fbe_pkg::fbe_stage_t stage_out
);
  import fbe_pkg::*;

  localparam rot_t KEY_ROT   = key_rot_amt(ROUND_IDX);
  localparam key_t KEY_CONST = key_const(ROUND_IDX);

  key_t  round_key;
  half_t mixed;
  half_t subst;
  half_t left_nxt;
  half_t right_nxt;
  logic  valid_r;
  half_t left_r;
  half_t right_r;

  // The round key is wiring of the master key plus a constant.
  assign round_key = rotl128(cipher_key, KEY_ROT) ^ KEY_CONST;
  assign mixed     = stage_in.right ^ round_key[KEY_W-1:HALF_W];

  // Byte-wise substitution; each S-box entry is an affine function of the seed.
  always_comb begin
    for (int b = 0; b < BYTES_PER_HALF; b++) begin
      subst[b*BYTE_W +: BYTE_W] =
        byte_t'(SBOX_MUL_TBL[mixed[b*BYTE_W +: BYTE_W]] * sbox_seed)
        + SBOX_ADD_TBL[mixed[b*BYTE_W +: BYTE_W]];
    end
  end

  // Swap the halves and fold the round function into the old left half.
  assign left_nxt  = stage_in.right;
  assign right_nxt = stage_in.left ^ subst ^ round_key[HALF_W-1:0];

  // Valid bit: cleared on reset, moves with the pipeline enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_in.valid;
    end
  end

  // Payload registers hold while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign stage_out = {valid_r, left_r, right_r};

endmodule

@@ hdl/fbe_skid.sv @@
// Two-entry output buffer that decouples the cipher pipeline from the result channel.
module fbe_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  fbe_pkg::fbe_stage_t stage_in,
  output logic                in_ready,
  fbe_out_if.source           out_ch
);
  import fbe_pkg::*;

  logic  main_valid_r, main_valid_nxt;
  logic  spare_valid_r, spare_valid_nxt;
  half_t main_high_r, main_high_nxt;
  half_t main_low_r, main_low_nxt;
  half_t spare_high_r, spare_high_nxt;
  half_t spare_low_r, spare_low_nxt;
  logic  push;
  logic  pop;

  assign in_ready = !spare_valid_r;
  assign push     = stage_in.valid && in_ready;
  assign pop      = main_valid_r && out_ch.ready;

  // Next state of the two entries.
  always_comb begin
    main_valid_nxt  = main_valid_r;
    spare_valid_nxt = spare_valid_r;
    main_high_nxt   = main_high_r;
    main_low_nxt    = main_low_r;
    spare_high_nxt  = spare_high_r;
    spare_low_nxt   = spare_low_r;
    if (pop) begin
      if (spare_valid_r) begin
        main_high_nxt   = spare_high_r;
        main_low_nxt    = spare_low_r;
        spare_valid_nxt = 1'b0;
      end else if (push) begin
        main_high_nxt  = stage_in.left;
        main_low_nxt   = stage_in.right;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r) begin
        spare_high_nxt  = stage_in.left;
        spare_low_nxt   = stage_in.right;
        spare_valid_nxt = 1'b1;
      end else begin
        main_high_nxt  = stage_in.left;
        main_low_nxt   = stage_in.right;
        main_valid_nxt = 1'b1;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r  <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      main_valid_r  <= main_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    main_high_r  <= main_high_nxt;
    main_low_r   <= main_low_nxt;
    spare_high_r <= spare_high_nxt;
    spare_low_r  <= spare_low_nxt;
  end

  assign out_ch.valid       = main_valid_r;
  assign out_ch.cipher_high = main_high_r;
  assign out_ch.cipher_low  = main_low_r;

endmodule

@@ hdl/feistel_block_encrypt.sv @@
// Top level of the pipelined Feistel block cipher.
//
//  Channel  Direction  Request carries                    Accepted when
//  in_ch    in         block_high, block_low              in_ch.valid & in_ch.ready
//  out_ch   out        cipher_high, cipher_low            out_ch.valid & out_ch.ready
//  cfg_ch   in         index, wdata (key_high/low, seed)  cfg_ch.valid & cfg_ch.ready
//
// One round per register stage: a block can be accepted every cycle unless the pipeline
// is stalled; its result passes through the round registers and then the output buffer
// register before it can be taken on out_ch.
// Round keys and S-box entries are formed from the key and seed registers as
// logic, so a configuration write takes effect on the next cycle with no rebuild.
// Synchronous reset clears the valid bits and the configuration registers.
// On a stall the whole pipeline holds; the two-entry output buffer keeps in_ch.ready
// off the combinational path from out_ch.ready.
module feistel_block_encrypt #(
  parameter int ROUND_COUNT = fbe_pkg::ROUND_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fbe_in_if.sink    in_ch,
  fbe_out_if.source out_ch,
  fbe_cfg_if.sink   cfg_ch
);
  import fbe_pkg::*;

  half_t      key_high_r, key_high_nxt;
  half_t      key_low_r, key_low_nxt;
  byte_t      seed_r, seed_nxt;
  key_t       cipher_key;
  fbe_stage_t stage [ROUND_COUNT+1];
  logic       pipe_en;
  logic       skid_ready;

  // Configuration writes; an unknown index is ignored.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    seed_nxt     = seed_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KEY_HIGH:  key_high_nxt = cfg_ch.wdata;
        REG_KEY_LOW:   key_low_nxt  = cfg_ch.wdata;
        REG_SBOX_SEED: seed_nxt     = cfg_ch.wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      seed_r     <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      seed_r     <= seed_nxt;
    end
  end

  assign cipher_key = {key_high_r, key_low_r};

  // The pipeline advances unless the last stage holds a block the buffer cannot take.
  assign pipe_en     = !stage[ROUND_COUNT].valid || skid_ready;
  assign in_ch.ready = pipe_en;

  assign stage[0].valid = in_ch.valid;
  assign stage[0].left  = in_ch.block_high;
  assign stage[0].right = in_ch.block_low;

  // Round stages.
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    fbe_round #(
      .ROUND_IDX (i)
    ) u_round (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (pipe_en),
      .cipher_key (cipher_key),
      .sbox_seed  (seed_r),
      .stage_in   (stage[i]),
      .stage_out  (stage[i+1])
    );
  end

  // Output buffer.
  fbe_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage_in (stage[ROUND_COUNT]),
    .in_ready (skid_ready),
    .out_ch   (out_ch)
  );

endmodule
